[hdl/q2av_pkg.sv]
// Package with shared types, constants and arithmetic helpers of the quaternion to axis vectors unit.
package q2av_pkg;

   localparam int unsigned ElemWidth = 35;
   localparam int unsigned MagWidth = 34;
   localparam int unsigned ScaledWidth = 30;
   localparam int unsigned SumWidth = 62;
   localparam int unsigned RootWidth = 31;
   localparam int unsigned NumWidth = 45;
   localparam int unsigned OutWidth = 16;
   localparam int unsigned DivSteps = 16;
   // Magnitude, scaling, square and sum stages, root steps, divider set-up stage and divider steps.
   localparam int unsigned NormLatency = 5 + RootWidth + DivSteps;
   localparam logic [15:0] OutOne = 16'd16384;

   typedef logic signed [ElemWidth-1:0] elem_type;
   typedef logic [ScaledWidth-1:0] scaled_type;

   typedef struct packed {
      elem_type e0;
      elem_type e1;
      elem_type e2;
   } column_type;

   typedef struct packed {
      column_type cx;
      column_type cy;
      column_type cz;
   } columns_type;

   typedef struct packed {
      logic [OutWidth-1:0] v0;
      logic [OutWidth-1:0] v1;
      logic [OutWidth-1:0] v2;
   } vec_type;

   function automatic logic [MagWidth-1:0] mag(input elem_type v);
      logic [ElemWidth-1:0] t;
      t = v[ElemWidth-1] ? (~v + 1'b1) : v;
      return t[MagWidth-1:0];
   endfunction

endpackage

[hdl/q2av_front.sv]
// Front part: accepts quaternions and forms the three unnormalised rotation columns.
module q2av_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [63:0]         in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output q2av_pkg::columns_type out_cols
);
   import q2av_pkg::*;

   logic signed [15:0] qx, qy, qz, qw;
   logic        p_valid_ff, p_valid_in;
   logic signed [31:0] pww_ff, pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pxw_ff, pyz_ff;
   logic signed [31:0] pyw_ff, pzw_ff;
   logic        c_valid_ff, c_valid_in;
   columns_type cols_ff, cols_in;
   logic        c_adv, p_adv;

   localparam elem_type One = elem_type'(64'sd268435456);

   function automatic elem_type dbl(input logic signed [31:0] a, input logic signed [31:0] b,
                                     input logic sub, input logic diag);
      elem_type s;
      s = sub ? (elem_type'(a) - elem_type'(b)) : (elem_type'(a) + elem_type'(b));
      s = s <<< 1;
      if (diag) s = s - One;
      return s;
   endfunction

   assign qx = in_data[15:0];
   assign qy = in_data[31:16];
   assign qz = in_data[47:32];
   assign qw = in_data[63:48];

   assign c_adv = !c_valid_ff || out_ready;
   assign p_adv = !p_valid_ff || c_adv;
   assign in_ready = p_adv;
   assign out_valid = c_valid_ff;
   assign out_cols = cols_ff;

   always_comb begin
      p_valid_in = p_adv ? in_valid : p_valid_ff;
      c_valid_in = c_adv ? p_valid_ff : c_valid_ff;
      cols_in.cx.e0 = dbl(pww_ff, pxx_ff, 1'b0, 1'b1);
      cols_in.cx.e1 = dbl(pzw_ff, pxy_ff, 1'b0, 1'b0);
      cols_in.cx.e2 = dbl(pxz_ff, pyw_ff, 1'b1, 1'b0);
      cols_in.cy.e0 = dbl(pxy_ff, pzw_ff, 1'b1, 1'b0);
      cols_in.cy.e1 = dbl(pww_ff, pyy_ff, 1'b0, 1'b1);
      cols_in.cy.e2 = dbl(pxw_ff, pyz_ff, 1'b0, 1'b0);
      cols_in.cz.e0 = dbl(pyw_ff, pxz_ff, 1'b0, 1'b0);
      cols_in.cz.e1 = dbl(pyz_ff, pxw_ff, 1'b1, 1'b0);
      cols_in.cz.e2 = dbl(pww_ff, pzz_ff, 1'b0, 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         c_valid_ff <= c_valid_in;
      end
      if (p_adv && in_valid) begin
         pww_ff <= qw * qw;
         pxx_ff <= qx * qx;
         pyy_ff <= qy * qy;
         pzz_ff <= qz * qz;
         pxy_ff <= qx * qy;
         pxz_ff <= qx * qz;
         pxw_ff <= qx * qw;
         pyz_ff <= qy * qz;
         pyw_ff <= qy * qw;
         pzw_ff <= qz * qw;
      end
      if (c_adv && p_valid_ff) cols_ff <= cols_in;
   end
endmodule

[hdl/q2av_queue.sv]
// Short queue that decouples the front part from the back part.
module q2av_queue #(
   parameter int unsigned Depth = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  q2av_pkg::columns_type in_cols,
   output logic                  out_valid,
   input  logic                  out_ready,
   output q2av_pkg::columns_type out_cols
);
   import q2av_pkg::*;

   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

   columns_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_cols = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_in = push ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in = pop ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_cols;
   end
endmodule

[hdl/q2av_norm.sv]
// Pipelined normaliser of one column: block scaling, square root, three restoring divisions.
module q2av_norm (
   input  logic                  clock,
   input  logic                  en,
   input  q2av_pkg::column_type  in_col,
   output q2av_pkg::vec_type     out_vec
);
   import q2av_pkg::*;

   localparam int unsigned RootSteps = RootWidth;
   localparam int unsigned Dly = NormLatency - 1;

   // Stage A: magnitudes, signs, zero flag.
   logic [MagWidth-1:0] ma_ff [3];
   logic [2:0] sa_ff;
   logic za_ff;
   // Stage B: scaled magnitudes.
   scaled_type sb_ff [3];
   logic [Dly-1:0] zero_ff;
   logic [2:0] sign_ff [Dly];
   // Stage C: squares.
   logic [59:0] sq_ff [3];
   scaled_type sc_ff [3];
   // Root pipeline.
   logic [SumWidth-1:0] rn_ff [RootSteps+1];
   logic [SumWidth-1:0] rr_ff [RootSteps+1];
   scaled_type ra_ff [RootSteps+1][3];
   // Divider pipeline.
   logic [RootWidth-1:0] dd_ff [DivSteps+1];
   logic [NumWidth-1:0] rem_ff [DivSteps+1][3];
   logic [15:0] dq_ff [DivSteps+1][3];

   logic [MagWidth-1:0] mx;
   logic [5:0] lz;
   logic [SumWidth-1:0] bitv [RootSteps];

   always_comb begin
      mx = ma_ff[0];
      if (ma_ff[1] > mx) mx = ma_ff[1];
      if (ma_ff[2] > mx) mx = ma_ff[2];
      lz = 6'd0;
      for (int i = 0; i < MagWidth; i++) begin
         if (mx[i]) lz = 6'(i);
      end
   end

   genvar g;
   for (g = 0; g < RootSteps; g++) begin : g_bit
      assign bitv[g] = SumWidth'(64'd1 << (60 - 2*g));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff[0] <= mag(in_col.e0);
         ma_ff[1] <= mag(in_col.e1);
         ma_ff[2] <= mag(in_col.e2);
         sa_ff <= {in_col.e2[ElemWidth-1], in_col.e1[ElemWidth-1], in_col.e0[ElemWidth-1]};
         za_ff <= (in_col.e0 == '0) && (in_col.e1 == '0) && (in_col.e2 == '0);
         for (int i = 0; i < 3; i++) begin
            if (lz >= 6'd29) sb_ff[i] <= ScaledWidth'(ma_ff[i] >> (lz - 6'd29));
            else sb_ff[i] <= ScaledWidth'(ma_ff[i] << (6'd29 - lz));
         end
         zero_ff <= {zero_ff[Dly-2:0], za_ff};
         sign_ff[0] <= sa_ff;
         for (int s = 1; s < Dly; s++) sign_ff[s] <= sign_ff[s-1];
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sb_ff[i] * sb_ff[i];
            sc_ff[i] <= sb_ff[i];
         end
         rn_ff[0] <= SumWidth'(sq_ff[0]) + SumWidth'(sq_ff[1]) + SumWidth'(sq_ff[2]);
         rr_ff[0] <= '0;
         ra_ff[0] <= sc_ff;
         for (int s = 0; s < RootSteps; s++) begin
            if (rn_ff[s] >= rr_ff[s] + bitv[s]) begin
               rn_ff[s+1] <= rn_ff[s] - (rr_ff[s] + bitv[s]);
               rr_ff[s+1] <= (rr_ff[s] >> 1) + bitv[s];
            end else begin
               rn_ff[s+1] <= rn_ff[s];
               rr_ff[s+1] <= rr_ff[s] >> 1;
            end
            ra_ff[s+1] <= ra_ff[s];
         end
         dd_ff[0] <= RootWidth'(rr_ff[RootSteps]);
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (NumWidth'(ra_ff[RootSteps][i]) << 14)
                            + NumWidth'(rr_ff[RootSteps][RootWidth-1:1]);
            dq_ff[0][i] <= '0;
         end
         for (int s = 0; s < DivSteps; s++) begin
            dd_ff[s+1] <= dd_ff[s];
            for (int i = 0; i < 3; i++) begin
               if ((rem_ff[s][i] >> (DivSteps-1-s)) >= NumWidth'(dd_ff[s])) begin
                  rem_ff[s+1][i] <= rem_ff[s][i] - (NumWidth'(dd_ff[s]) << (DivSteps-1-s));
                  dq_ff[s+1][i] <= {dq_ff[s][i][14:0], 1'b1};
               end else begin
                  rem_ff[s+1][i] <= rem_ff[s][i];
                  dq_ff[s+1][i] <= {dq_ff[s][i][14:0], 1'b0};
               end
            end
         end
      end
   end

   function automatic logic [15:0] fin(input logic [15:0] q, input logic s, input logic z);
      logic [15:0] v;
      v = (q > OutOne) ? OutOne : q;
      if (z) v = '0;
      return s ? (~v + 1'b1) : v;
   endfunction

   assign out_vec.v0 = fin(dq_ff[DivSteps][0], sign_ff[Dly-1][0], zero_ff[Dly-1]);
   assign out_vec.v1 = fin(dq_ff[DivSteps][1], sign_ff[Dly-1][1], zero_ff[Dly-1]);
   assign out_vec.v2 = fin(dq_ff[DivSteps][2], sign_ff[Dly-1][2], zero_ff[Dly-1]);
endmodule

[hdl/q2av_back.sv]
// Back part: three column normalisers in a stalling pipeline with a registered output stage.
module q2av_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  q2av_pkg::columns_type in_cols,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [143:0]          out_data
);
   import q2av_pkg::*;

   localparam int unsigned Lat = NormLatency;

   logic [Lat-1:0] v_ff, v_in;
   logic en;
   vec_type vx, vy, vz;
   logic o_valid_ff, o_valid_in;
   logic [143:0] o_data_ff;

   assign en = !o_valid_ff || out_ready || !v_ff[Lat-1];
   assign in_ready = en;
   assign out_valid = o_valid_ff;
   assign out_data = o_data_ff;

   always_comb begin
      v_in = en ? {v_ff[Lat-2:0], in_valid} : v_ff;
      o_valid_in = o_valid_ff && !out_ready;
      if (en && v_ff[Lat-1]) o_valid_in = 1'b1;
   end

   q2av_norm u_nx (.clock(clock), .en(en), .in_col(in_cols.cx), .out_vec(vx));
   q2av_norm u_ny (.clock(clock), .en(en), .in_col(in_cols.cy), .out_vec(vy));
   q2av_norm u_nz (.clock(clock), .en(en), .in_col(in_cols.cz), .out_vec(vz));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
         o_valid_ff <= o_valid_in;
      end
      if (en && v_ff[Lat-1]) begin
         o_data_ff <= {vz.v2, vz.v1, vz.v0, vy.v2, vy.v1, vy.v0, vx.v2, vx.v1, vx.v0};
      end
   end
endmodule

[hdl/quaternion_to_axis_vectors_unit.sv]
// Top level of the quaternion to axis vectors unit.
//  Channel | Direction | Contents
//  req_    | in        | one quaternion x, y, z, w per transaction
//  rsp_    | out       | X, Y and Z axis vectors per transaction
// One transaction is accepted per cycle when the output is not stalled.
// A result passes through two front stages, one in the queue, 52 in the normalisers (31-step
// square root, 16-step divider) and the output register.
// Reset clears only the valid flags and the queue pointers and count; a stalled output holds the
// back pipeline while the queue lets the front part keep accepting up to its depth.
module quaternion_to_axis_vectors_unit #(
   parameter int unsigned QueueDepth = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // quat_x, quat_y, quat_z, quat_w
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata   // xaxis_x,y,z, yaxis_x,y,z, zaxis_x,y,z
);
   import q2av_pkg::*;

   logic f_valid, f_ready, b_valid, b_ready;
   columns_type f_cols, b_cols;

   q2av_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata), .out_valid(f_valid), .out_ready(f_ready), .out_cols(f_cols)
   );

   q2av_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready),
      .in_cols(f_cols), .out_valid(b_valid), .out_ready(b_ready), .out_cols(b_cols)
   );

   q2av_back u_back (
      .clock(clock), .reset(reset), .in_valid(b_valid), .in_ready(b_ready),
      .in_cols(b_cols), .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );
endmodule
